@@ sv/hftq_pkg.sv @@
// ----------------------------------------------------------------------------
// hftq_pkg
// Types and constants shared by the heightfield triangle height query block.
// ----------------------------------------------------------------------------
package hftq_pkg;

  localparam int H_W         = 18;
  localparam int ELEV_W      = 18;
  localparam int CFG_W       = 9;
  localparam int CFG_IDX_W   = 1;
  localparam int HEIGHT_BIAS = 65536;
  localparam int ELEV_LIMIT  = 65536;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_DEPTH = 1'b1;

  typedef struct packed {
    logic               func;
    logic [7:0]         column;
    logic [7:0]         row;
    logic [15:0]        sample;
    logic signed [15:0] query_x;
    logic signed [15:0] query_z;
  } in_item_t;

  typedef struct packed {
    logic signed [ELEV_W-1:0] elevation;
    logic                     out_of_range;
  } out_item_t;

endpackage

@@ sv/hftq_ram.sv @@
// ----------------------------------------------------------------------------
// hftq_ram
// Single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module hftq_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ sv/heightfield_triangle_height_query.sv @@
// ----------------------------------------------------------------------------
// heightfield_triangle_height_query
// Height grid store with triangle-interpolated height queries.
// ----------------------------------------------------------------------------
// Input items are taken at a clock edge where start is high and busy is low.
// A write item (func 0) stores one sample in that cycle if its cell is in the
// grid, and gives no result; the next item may follow in the next cycle.
// A query item (func 1) gives exactly one result on out_data, marked by
// out_valid for one cycle. A query whose cell is outside the grid answers in
// the cycle after acceptance and leaves busy low. Any other query reads three
// corners from the single-port grid RAM one after another, then runs both
// slope products through one shared multiplier. Busy stays high until the
// result is registered, so no new item is taken while a query runs; the RAM
// port and the multiplier, each shared by all steps, set this pace.
// The receiver cannot stall; results must be taken when out_valid is high.
// cfg_we writes grid_width (index 0) or grid_depth (index 1); write only
// while idle. Reset restores a 256 by 256 grid and drops any item in flight;
// grid contents are undefined until written.
// ----------------------------------------------------------------------------
module heightfield_triangle_height_query #(
  parameter int MAX_DIM   = 256,
  parameter int FRAC_BITS = 8
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  hftq_pkg::in_item_t                   in_data,
  output logic                                 out_valid,
  output hftq_pkg::out_item_t                  out_data,
  input  logic                                 cfg_we,
  input  logic [hftq_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [hftq_pkg::CFG_W-1:0]           cfg_data
);
  import hftq_pkg::*;

  localparam int DW    = ($clog2(MAX_DIM + 1) > CFG_W) ? $clog2(MAX_DIM + 1) : CFG_W;
  localparam int NW    = ((DW + FRAC_BITS > 16) ? DW + FRAC_BITS : 16) + 2;
  localparam int CXW   = NW - FRAC_BITS;
  localparam int CW    = $clog2(MAX_DIM);
  localparam int AW    = $clog2(MAX_DIM * MAX_DIM);
  localparam int DIFF_W = H_W + 1;
  localparam int MUL_A_W = FRAC_BITS + 1;
  localparam int PW    = DIFF_W + MUL_A_W + 1;
  localparam int ACC_W = PW - FRAC_BITS;
  localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_RD01  = 8'b0000_0010,
    S_RD10  = 8'b0000_0100,
    S_RDB   = 8'b0000_1000,
    S_WAITB = 8'b0001_0000,
    S_MUL1  = 8'b0010_0000,
    S_MUL2  = 8'b0100_0000,
    S_SUM   = 8'b1000_0000
  } state_t;

  function automatic logic [AW-1:0] grid_addr(input logic [CW-1:0] cz,
                                              input logic [CW-1:0] cx);
    grid_addr = AW'(AW'(cz) * AW'(MAX_DIM) + AW'(cx));
  endfunction

  function automatic logic [DW-1:0] eff_dim(input logic [CFG_W-1:0] v);
    logic [DW-1:0] e;
    e = DW'(v);
    if (e < DW'(2)) begin
      eff_dim = DW'(2);
    end else if (e > DW'(MAX_DIM)) begin
      eff_dim = DW'(MAX_DIM);
    end else begin
      eff_dim = e;
    end
  endfunction

  state_t                    state_r, state_nxt;
  logic [CFG_W-1:0]          grid_width_r, grid_depth_r;
  logic [CW-1:0]             cx_r, cz_r;
  logic [MUL_A_W-1:0]        f1_r, f2_r;
  logic                      far_r;
  logic signed [H_W-1:0]     h01_r, h10_r, base_r;
  logic signed [PW-1:0]      prod_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic                      out_valid_r;
  out_item_t                 out_r;

  logic [DW-1:0]             eff_w, eff_d;
  logic                      accept, wr_ok, ram_we;
  logic signed [NW-1:0]      nx, nz;
  logic [CXW-1:0]            cxu, czu;
  logic [FRAC_BITS-1:0]      dx, dz;
  logic                      oor, far;
  logic [AW-1:0]             ram_addr;
  logic [H_W-1:0]            ram_wdata, ram_rdata;
  logic signed [H_W-1:0]     rdata_s;
  logic [MUL_A_W-1:0]        mul_a;
  logic signed [H_W-1:0]     mul_h;
  logic signed [DIFF_W-1:0]  mul_b;
  logic signed [PW-1:0]      mul_p;
  logic signed [ACC_W-1:0]   term, sum;
  logic signed [ELEV_W-1:0]  elev_sat;

  assign eff_w  = eff_dim(grid_width_r);
  assign eff_d  = eff_dim(grid_depth_r);
  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  assign wr_ok  = (DW'(in_data.column) < eff_w) && (DW'(in_data.row) < eff_d);
  assign ram_we = accept && (in_data.func == FUNC_WRITE) && wr_ok;
  assign ram_wdata = H_W'({in_data.sample, 1'b0}) - H_W'(HEIGHT_BIAS);

  assign nx  = NW'(in_data.query_x) + $signed(NW'(eff_w) << (FRAC_BITS - 1));
  assign nz  = NW'(in_data.query_z) + $signed(NW'(eff_d) << (FRAC_BITS - 1));
  assign cxu = nx[NW-1:FRAC_BITS];
  assign czu = nz[NW-1:FRAC_BITS];
  assign dx  = nx[FRAC_BITS-1:0];
  assign dz  = nz[FRAC_BITS-1:0];
  assign oor = nx[NW-1] || nz[NW-1] ||
               (cxu + CXW'(2) > CXW'(eff_w)) || (czu + CXW'(2) > CXW'(eff_d));
  assign far = ({1'b0, dx} + {1'b0, dz}) > ONE;

  always_comb begin
    unique case (state_r)
      S_RD01:  ram_addr = grid_addr(cz_r + CW'(1), cx_r);
      S_RD10:  ram_addr = grid_addr(cz_r, cx_r + CW'(1));
      S_RDB:   ram_addr = far_r ? grid_addr(cz_r + CW'(1), cx_r + CW'(1))
                                : grid_addr(cz_r, cx_r);
      default: ram_addr = grid_addr(CW'(in_data.row), CW'(in_data.column));
    endcase
  end

  hftq_ram #(
    .WIDTH (H_W),
    .DEPTH (MAX_DIM * MAX_DIM)
  ) u_grid (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign rdata_s = $signed(ram_rdata);

  // shared slope multiplier
  assign mul_a = state_r[5] ? f1_r : f2_r;
  always_comb begin
    if (state_r[5]) begin
      mul_h = far_r ? h01_r : h10_r;
    end else begin
      mul_h = far_r ? h10_r : h01_r;
    end
  end
  assign mul_b = DIFF_W'(mul_h) - DIFF_W'(base_r);
  assign mul_p = $signed({1'b0, mul_a}) * mul_b;

  assign term = prod_r[PW-1:FRAC_BITS];
  assign sum  = acc_r + term;

  always_comb begin
    if (sum < -ACC_W'(ELEV_LIMIT)) begin
      elev_sat = -ELEV_W'(ELEV_LIMIT);
    end else if (sum > ACC_W'(ELEV_LIMIT)) begin
      elev_sat = ELEV_W'(ELEV_LIMIT);
    end else begin
      elev_sat = sum[ELEV_W-1:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (accept && in_data.func == FUNC_QUERY && !oor) state_nxt = S_RD01;
      S_RD01:  state_nxt = S_RD10;
      S_RD10:  state_nxt = S_RDB;
      S_RDB:   state_nxt = S_WAITB;
      S_WAITB: state_nxt = S_MUL1;
      S_MUL1:  state_nxt = S_MUL2;
      S_MUL2:  state_nxt = S_SUM;
      S_SUM:   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      grid_width_r <= CFG_W'(256);
      grid_depth_r <= CFG_W'(256);
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == S_SUM) ||
                     (accept && in_data.func == FUNC_QUERY && oor);
      if (cfg_we) begin
        unique case (cfg_index)
          REG_GRID_WIDTH: grid_width_r <= cfg_data;
          REG_GRID_DEPTH: grid_depth_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cx_r  <= CW'(cxu);
      cz_r  <= CW'(czu);
      far_r <= far;
      f1_r  <= far ? ONE - {1'b0, dx} : {1'b0, dx};
      f2_r  <= far ? ONE - {1'b0, dz} : {1'b0, dz};
    end
    if (state_r == S_RD10) h01_r  <= rdata_s;
    if (state_r == S_RDB)  h10_r  <= rdata_s;
    if (state_r == S_WAITB) base_r <= rdata_s;
    if (state_r == S_MUL1) prod_r <= mul_p;
    if (state_r == S_MUL2) begin
      prod_r <= mul_p;
      acc_r  <= ACC_W'(base_r) + term;
    end
    if (state_r == S_SUM) begin
      out_r.elevation    <= elev_sat;
      out_r.out_of_range <= 1'b0;
    end else if (accept && in_data.func == FUNC_QUERY && oor) begin
      out_r.elevation    <= '0;
      out_r.out_of_range <= 1'b1;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_interp_from_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.out_of_range |-> $past(state_r == S_SUM))
    else $error("interpolated result without finished sequence");

  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.out_of_range |-> out_data.elevation == '0)
    else $error("out-of-range result with nonzero elevation");

  a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_data.func == FUNC_WRITE |=> !out_valid)
    else $error("write item produced a result");

  a_ram_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> state_r == S_IDLE)
    else $error("grid write during a query");

  a_elev_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.elevation >= -ELEV_W'(ELEV_LIMIT)) &&
                  (out_data.elevation <= ELEV_W'(ELEV_LIMIT)))
    else $error("elevation outside saturation range");

endmodule
